// ===== hw/rtl/bgi_pkg.sv =====
// Shared types and constants for the bilinear grid interpolation block.
`default_nettype none
package bgi_pkg;
  localparam logic [1:0] OP_LOAD_X = 2'd0;
  localparam logic [1:0] OP_LOAD_Y = 2'd1;
  localparam logic [1:0] OP_LOAD_G = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  localparam logic CFG_X_COUNT = 1'b0;
  localparam logic CFG_Y_COUNT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;   // latch the accepted item and do its load
    logic scan_start;  // reset scan state
    logic scan_step;   // compare one interval on each axis
    logic scan_done;   // latch interval widths and offsets
    logic div_start;   // start both fraction divisions, clear acc
    logic div_step;    // one quotient bit on each axis
    logic corner_rd;   // read one corner sample (index in corner_sel)
    logic [1:0] corner_sel;
    logic mac_step;    // accumulate one weighted corner
    logic finish;      // form result into output register
  } bgi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_query;
    logic scan_last;
    logic div_last;
  } bgi_sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/bgi_datapath.sv =====
// Datapath: breakpoint and sample stores, scan, serial dividers and blend.
`default_nettype none
module bgi_datapath #(
  parameter int MAX_X_POINTS = 16,
  parameter int MAX_Y_POINTS = 16
) (
  input  wire logic            clk,
  input  wire logic [1:0]      opcode,
  input  wire logic [3:0]      row_index,
  input  wire logic [3:0]      column_index,
  input  wire logic [31:0]     load_value,
  input  wire logic [31:0]     query_x,
  input  wire logic [31:0]     query_y,
  input  wire logic [4:0]      x_count,
  input  wire logic [4:0]      y_count,
  input  wire bgi_pkg::bgi_cmd_t cmd,
  output bgi_pkg::bgi_sts_t    sts,
  output logic [31:0]          interpolated_value,
  output logic                 lookup_failed
);
  import bgi_pkg::*;

  localparam int XW = (MAX_X_POINTS > 1) ? $clog2(MAX_X_POINTS) : 1;
  localparam int YW = (MAX_Y_POINTS > 1) ? $clog2(MAX_Y_POINTS) : 1;
  localparam int GD = MAX_X_POINTS * MAX_Y_POINTS;
  localparam int GW = $clog2(GD);
  localparam int SW = (XW > YW ? XW : YW) + 1;

  // Stores (contents undefined until written).
  logic signed [31:0] xbp [MAX_X_POINTS];
  logic signed [31:0] ybp [MAX_Y_POINTS];
  logic signed [31:0] grid [GD];

  logic signed [31:0] qx, qy;
  logic [SW-1:0] scan_i, xn, yn;
  logic signed [31:0] xa, xb, ya, yb;
  logic [XW-1:0] xfound;
  logic [YW-1:0] yfound;
  logic xhit, yhit, fail;
  logic [32:0] xw, yw, xr, yr;
  logic [48:0] xd, yd;
  logic [16:0] fx, fy;
  logic [5:0] div_cnt;
  logic signed [31:0] samp;
  logic signed [33:0] wgt;
  logic signed [63:0] acc;
  logic signed [65:0] prod;
  logic is_query;

  // Clamp configured counts into the legal range.
  always_comb begin
    if (x_count < 5'd2) xn = SW'(2);
    else if (32'(x_count) > MAX_X_POINTS) xn = SW'(MAX_X_POINTS);
    else xn = SW'(x_count);
    if (y_count < 5'd2) yn = SW'(2);
    else if (32'(y_count) > MAX_Y_POINTS) yn = SW'(MAX_Y_POINTS);
    else yn = SW'(y_count);
  end

  assign sts.is_query  = is_query;
  assign sts.scan_last = (scan_i + SW'(2) >= xn) && (scan_i + SW'(2) >= yn);
  assign sts.div_last  = (div_cnt == 6'd48);

  // Whether the current interval is within the clamped point count on each axis.
  logic in_x, in_y;
  assign in_x = (scan_i + SW'(1) < xn) && (32'(scan_i) + 1 < MAX_X_POINTS);
  assign in_y = (scan_i + SW'(1) < yn) && (32'(scan_i) + 1 < MAX_Y_POINTS);

  // Division remainders for one restoring step.
  logic [33:0] xr2, yr2;
  assign xr2 = {xr, xd[48]};
  assign yr2 = {yr, yd[48]};

  // The fractions are the low quotient bits once the division has finished.
  assign fx = xd[16:0];
  assign fy = yd[16:0];

  // Complements of the fractions (one minus each), in the same scale.
  logic [16:0] gx, gy;
  assign gx = 17'h10000 - fx;
  assign gy = 17'h10000 - fy;

  // Signed product of a corner sample and its weight.
  assign prod = samp * wgt;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      is_query <= (opcode == OP_QUERY);
      qx <= query_x;
      qy <= query_y;
      unique case (opcode)
        OP_LOAD_X: if (32'(column_index) < MAX_X_POINTS)
          xbp[column_index[XW-1:0]] <= load_value;
        OP_LOAD_Y: if (32'(row_index) < MAX_Y_POINTS)
          ybp[row_index[YW-1:0]] <= load_value;
        OP_LOAD_G: if (32'(row_index) < MAX_Y_POINTS && 32'(column_index) < MAX_X_POINTS)
          grid[GW'(32'(row_index) * MAX_X_POINTS + 32'(column_index))] <= load_value;
        default: ;
      endcase
    end
    if (cmd.scan_start) begin
      scan_i <= '0;
      xhit <= 1'b0;
      yhit <= 1'b0;
    end
    // One interval per axis per cycle; later hits override earlier ones.
    if (cmd.scan_step) begin
      scan_i <= scan_i + SW'(1);
      if (in_x && qx >= xbp[scan_i[XW-1:0]] && qx <= xbp[XW'(scan_i + SW'(1))]) begin
        xhit <= 1'b1;
        xfound <= scan_i[XW-1:0];
        xa <= xbp[scan_i[XW-1:0]];
        xb <= xbp[XW'(scan_i + SW'(1))];
      end
      if (in_y && qy >= ybp[scan_i[YW-1:0]] && qy <= ybp[YW'(scan_i + SW'(1))]) begin
        yhit <= 1'b1;
        yfound <= scan_i[YW-1:0];
        ya <= ybp[scan_i[YW-1:0]];
        yb <= ybp[YW'(scan_i + SW'(1))];
      end
    end
    // The offset from the lower breakpoint fits 32 bits; the dividend is that
    // offset times 2^16, placed so the first step takes its top bit.
    if (cmd.scan_done) begin
      xw <= 33'({xb[31], xb}) - 33'({xa[31], xa});
      yw <= 33'({yb[31], yb}) - 33'({ya[31], ya});
      xd <= {32'(qx - xa), 17'd0};
      yd <= {32'(qy - ya), 17'd0};
      fail <= !xhit || !yhit || (xb == xa) || (yb == ya);
    end
    // Restoring division, one quotient bit per cycle.
    if (cmd.div_start) begin
      xr <= '0;
      yr <= '0;
      div_cnt <= '0;
      acc <= '0;
    end
    if (cmd.div_step) begin
      div_cnt <= div_cnt + 6'd1;
      xd <= {xd[47:0], (xr2 >= {1'b0, xw})};
      yd <= {yd[47:0], (yr2 >= {1'b0, yw})};
      if (xr2 >= {1'b0, xw}) xr <= 33'(xr2 - {1'b0, xw});
      else xr <= xr2[32:0];
      if (yr2 >= {1'b0, yw}) yr <= 33'(yr2 - {1'b0, yw});
      else yr <= yr2[32:0];
    end
    // Registered corner read, with its Q.32 weight.
    if (cmd.corner_rd) begin
      samp <= grid[GW'((32'(yfound) + 32'(cmd.corner_sel[1])) * MAX_X_POINTS
                       + 32'(xfound) + 32'(cmd.corner_sel[0]))];
      wgt <= 34'((cmd.corner_sel[0] ? 34'(fx) : 34'(gx)) *
                 (cmd.corner_sel[1] ? 34'(fy) : 34'(gy)));
    end
    if (cmd.mac_step) acc <= acc + $signed(prod[63:0]);
    if (cmd.finish) begin
      lookup_failed <= fail;
      interpolated_value <= fail ? 32'd0 : 32'((acc + 64'sh80000000) >>> 32);
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bgi_ctrl.sv =====
// Controller state machine sequencing the query steps and the handshakes.
`default_nettype none
module bgi_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_fire,
  input  wire logic              out_fire,
  input  wire bgi_pkg::bgi_sts_t sts,
  output bgi_pkg::bgi_cmd_t      cmd,
  output logic                   in_ready,
  output logic                   out_valid
);
  import bgi_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MAC  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state, state_next;
  logic [2:0] k, k_next;
  logic out_valid_next;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    state_next = state;
    k_next = k;
    out_valid_next = out_valid && !out_fire;
    unique case (state)
      S_IDLE: if (in_fire) begin
        cmd.load_item = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        cmd.scan_start = 1'b1;
        state_next = sts.is_query ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (k == 3'd0) begin
          cmd.scan_done = 1'b1;
          k_next = 3'd1;
        end else if (k == 3'd1) begin
          cmd.div_start = 1'b1;
          k_next = 3'd2;
        end else if (!sts.div_last) begin
          cmd.div_step = 1'b1;
        end else begin
          k_next = 3'd0;
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        // k 0..3 reads corners, k 1..4 accumulates the previous one.
        if (k < 3'd4) begin
          cmd.corner_rd = 1'b1;
          cmd.corner_sel = k[1:0];
        end
        if (k != 3'd0) cmd.mac_step = 1'b1;
        k_next = k + 3'd1;
        if (k == 3'd4) begin
          k_next = 3'd0;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      k <= k_next;
      out_valid <= out_valid_next;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bilinear_grid_interpolation.sv =====
// Top level of the bilinear grid interpolation block.
// Input items arrive on the s_axis group: opcode in tuser, the other fields
// in tdata. A load passes through the decode state and gives no result.
// A query scans one interval per axis per cycle, runs both fraction
// divisions bit-serially side by side, then reads and accumulates the four
// corners, and shows its result on m_axis.
// One item is processed at a time; a result waits in the output register
// until taken, and no new item is accepted while it waits.
// Reset clears the control state and sets both point counts to 2; the
// breakpoint and sample stores hold nothing defined until written.
// Configuration writes are taken at any edge with cfg_we high and rst low.
`default_nettype none
module bilinear_grid_interpolation #(
  parameter int MAX_X_POINTS = 16,
  parameter int MAX_Y_POINTS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: row_index[3:0], column_index[7:4], load_value[39:8],
  // query_x[71:40], query_y[103:72]
  input  wire logic [103:0] s_axis_tdata,
  input  wire logic [1:0]   s_axis_tuser, // tuser: opcode[1:0]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [31:0]       m_axis_tdata, // tdata: interpolated_value[31:0]
  output logic              m_axis_tuser, // tuser: lookup_failed
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [4:0]   cfg_data
);
  import bgi_pkg::*;

  logic [4:0] x_count, y_count;
  bgi_cmd_t cmd;
  bgi_sts_t sts;

  // Point count registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_count <= 5'd2;
      y_count <= 5'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_COUNT: x_count <= cfg_data;
        CFG_Y_COUNT: y_count <= cfg_data;
        default: ;
      endcase
    end
  end

  bgi_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(s_axis_tvalid && s_axis_tready),
    .out_fire(m_axis_tvalid && m_axis_tready),
    .sts(sts), .cmd(cmd),
    .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
  );

  bgi_datapath #(.MAX_X_POINTS(MAX_X_POINTS), .MAX_Y_POINTS(MAX_Y_POINTS)) u_dp (
    .clk(clk),
    .opcode(s_axis_tuser),
    .row_index(s_axis_tdata[3:0]),
    .column_index(s_axis_tdata[7:4]),
    .load_value(s_axis_tdata[39:8]),
    .query_x(s_axis_tdata[71:40]),
    .query_y(s_axis_tdata[103:72]),
    .x_count(x_count), .y_count(y_count),
    .cmd(cmd), .sts(sts),
    .interpolated_value(m_axis_tdata),
    .lookup_failed(m_axis_tuser)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/bgi_checker.sv =====
// Port-level checker for the bilinear grid interpolation block, with bind.
`default_nettype none
module bgi_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [1:0]   s_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [31:0]  m_axis_tdata,
  input wire logic         m_axis_tuser
);
  import bgi_pkg::*;

  // A failed lookup always reports zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0) else $error("fail nonzero");
  // No new item is taken while a result waits.
  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
  // A result stays until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  // A load produces no result: the output stays invalid after its decode step.
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != OP_QUERY |=> ##1 !m_axis_tvalid)
    else $error("load produced result");
endmodule

bind bilinear_grid_interpolation bgi_checker u_bgi_checker (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tuser(s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire
